@@ rtl/spg_pkg.sv @@
// shared constants and types for the sorted permutation generator
package spg_pkg;

    localparam int DEF_MAX_LEN = 8;
    localparam int STORE_DEPTH = 8;
    localparam int IDX_W       = 3;
    localparam int LEN_W       = 4;
    localparam int CHAR_W      = 8;
    localparam int ADDR_W      = IDX_W + 1;
    localparam int MEM_DEPTH   = 2 * STORE_DEPTH;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_NEXT = 1'b1;

    // choice stack command from the sequencer
    typedef struct packed {
        logic             restart;
        logic             bump;
        logic [IDX_W-1:0] idx;
    } stack_cmd_t;

    // request to the shared compare and swap unit
    typedef struct packed {
        logic              force_swap;
        logic [CHAR_W-1:0] a;
        logic [CHAR_W-1:0] b;
    } swap_req_t;

    // answer of the shared compare and swap unit
    typedef struct packed {
        logic              gt;
        logic [CHAR_W-1:0] first;
        logic [CHAR_W-1:0] second;
    } swap_rsp_t;

endpackage

@@ rtl/spg_mem.sv @@
// character memory: stored word in the low half, working permutation in the high half
module spg_mem (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [spg_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [spg_pkg::CHAR_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [spg_pkg::ADDR_W-1:0]  rd_addr,
    output logic [spg_pkg::CHAR_W-1:0]  rd_data
);
    import spg_pkg::*;

    logic [CHAR_W-1:0] mem_reg [MEM_DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/spg_swap_unit.sv @@
// shared compare and conditional swap unit
module spg_swap_unit (
    input  spg_pkg::swap_req_t req,
    output spg_pkg::swap_rsp_t rsp
);
    import spg_pkg::*;

    logic gt;
    logic do_swap;

    assign gt      = req.a > req.b;
    assign do_swap = req.force_swap | gt;

    assign rsp.gt     = gt;
    assign rsp.first  = do_swap ? req.b : req.a;
    assign rsp.second = do_swap ? req.a : req.b;

endmodule

@@ rtl/spg_stack.sv @@
// choice stack of the swap recursion, kept as an odometer
module spg_stack (
    input  logic                       clk,
    input  logic                       rst_n,
    input  spg_pkg::stack_cmd_t        cmd,
    output logic [spg_pkg::IDX_W-1:0]  choice
);
    import spg_pkg::*;

    logic [IDX_W-1:0] stack_reg  [STORE_DEPTH];
    logic [IDX_W-1:0] stack_next [STORE_DEPTH];

    always_comb
    begin
        for (int m = 0; m < STORE_DEPTH; m++)
        begin
            stack_next[m] = stack_reg[m];
            if (cmd.restart)
            begin
                stack_next[m] = IDX_W'(m);
            end
            else if (cmd.bump)
            begin
                if (IDX_W'(m) > cmd.idx)
                begin
                    stack_next[m] = IDX_W'(m);
                end
                else if (IDX_W'(m) == cmd.idx)
                begin
                    stack_next[m] = stack_reg[m] + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < STORE_DEPTH; m++)
            begin
                stack_reg[m] <= '0;
            end
        end
        else
        begin
            for (int m = 0; m < STORE_DEPTH; m++)
            begin
                stack_reg[m] <= stack_next[m];
            end
        end
    end

    assign choice = stack_reg[cmd.idx];

endmodule

@@ rtl/sorted_permutation_generator_top.sv @@
// top level: sequencer around the shared swap unit, character memory and choice stack
// a plain load writes its character from idle; a closing load of n characters then
//   bubble-sorts the store, n(n-1)/2 compares through XA to XD, before the next
//   request is taken; a next request copies the word (COPY), swaps pairs (XA to XD),
//   emits each character via EM_RD and EM_LD, holding while the result stalls, then
//   walks odometer levels down (ADV); reset: control, word length and choice stack clear,
//   nothing is pending; memory stays undefined until written and has a single read port
module sorted_permutation_generator_top #(
    parameter int MAX_LEN = spg_pkg::DEF_MAX_LEN
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic                       action,
    input  logic [spg_pkg::CHAR_W-1:0] char_value,
    input  logic                       last_char,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [spg_pkg::CHAR_W-1:0] char_out,
    output logic                       last_of_perm,
    output logic                       exhausted
);
    import spg_pkg::*;

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_COPY  = 9'b000000010,
        ST_XA    = 9'b000000100,
        ST_XB    = 9'b000001000,
        ST_XC    = 9'b000010000,
        ST_XD    = 9'b000100000,
        ST_EM_RD = 9'b001000000,
        ST_EM_LD = 9'b010000000,
        ST_ADV   = 9'b100000000
    } state_t;

    // the compare and swap steps either sort the store or build a permutation
    typedef enum logic {
        MODE_SORT = 1'b0,
        MODE_PERM = 1'b1
    } mode_t;

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               closed_reg, closed_next;
    logic               done_reg, done_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   pass_reg, pass_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [CHAR_W-1:0]  a_reg, a_next;
    logic [CHAR_W-1:0]  b_reg, b_next;

    // output register
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;
    logic               out_exh_reg;
    logic               out_load;
    logic [CHAR_W-1:0]  out_char_next;
    logic               out_last_next;
    logic               out_exh_next;
    logic               out_free;

    // memory port
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [CHAR_W-1:0]  mem_wr_data;
    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic [CHAR_W-1:0]  mem_rd_data;

    stack_cmd_t         stack_cmd;
    logic [IDX_W-1:0]   choice;
    swap_req_t          swap_req;
    swap_rsp_t          swap_rsp;

    logic               item_fire;
    logic [LEN_W-1:0]   base_len;
    logic [LEN_W-1:0]   load_len;
    logic [ADDR_W-1:0]  x_addr;
    logic [ADDR_W-1:0]  y_addr;
    logic               emit_last;

    spg_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    spg_stack u_stack (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (stack_cmd),
        .choice (choice)
    );

    spg_swap_unit u_swap (
        .req (swap_req),
        .rsp (swap_rsp)
    );

    // a new request is taken only when idle and the last result has left
    assign item_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign item_fire  = item_valid && item_ready;
    assign out_free   = !out_valid_reg || result_ready;

    // a load after a closed word starts a fresh word
    assign base_len = closed_reg ? '0 : len_reg;
    assign load_len = (base_len < LEN_W'(MAX_LEN)) ? base_len + LEN_W'(1) : base_len;

    // pair addresses: adjacent store slots when sorting, level and its choice otherwise
    assign x_addr = {mode_reg == MODE_PERM, k_reg};
    assign y_addr = (mode_reg == MODE_SORT) ? {1'b0, k_reg + IDX_W'(1)} : {1'b1, choice};

    assign emit_last = (cnt_reg + LEN_W'(1)) == len_reg;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        len_next    = len_reg;
        closed_next = closed_reg;
        done_next   = done_reg;
        k_next      = k_reg;
        pass_next   = pass_reg;
        cnt_next    = cnt_reg;
        a_next      = a_reg;
        b_next      = b_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;

        stack_cmd.restart = 1'b0;
        stack_cmd.bump    = 1'b0;
        stack_cmd.idx     = k_reg;

        swap_req.force_swap = (mode_reg == MODE_PERM);
        swap_req.a          = a_reg;
        swap_req.b          = mem_rd_data;

        out_load      = 1'b0;
        out_char_next = '0;
        out_last_next = 1'b0;
        out_exh_next  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (action == ACT_LOAD)
                    begin
                        // characters past the length cap are dropped
                        if (base_len < LEN_W'(MAX_LEN))
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = {1'b0, base_len[IDX_W-1:0]};
                            mem_wr_data = char_value;
                        end
                        len_next    = load_len;
                        closed_next = last_char;
                        if (last_char)
                        begin
                            stack_cmd.restart = 1'b1;
                            done_next         = (load_len == '0);
                            if (load_len >= LEN_W'(2))
                            begin
                                mode_next  = MODE_SORT;
                                k_next     = '0;
                                pass_next  = '0;
                                state_next = ST_XA;
                            end
                        end
                        else
                        begin
                            // an open word stops any running enumeration
                            done_next = 1'b1;
                        end
                    end
                    else if (done_reg || (len_reg == '0))
                    begin
                        out_load      = 1'b1;
                        out_char_next = '0;
                        out_last_next = 1'b1;
                        out_exh_next  = 1'b1;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = ST_COPY;
                    end
                end
            end

            ST_COPY:
            begin
                // read slot cnt while writing the slot read in the previous cycle
                if (cnt_reg < len_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = {1'b0, cnt_reg[IDX_W-1:0]};
                end
                if (cnt_reg != '0)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = {1'b1, cnt_reg[IDX_W-1:0] - IDX_W'(1)};
                    mem_wr_data = mem_rd_data;
                end
                cnt_next = cnt_reg + LEN_W'(1);
                if (cnt_reg == len_reg)
                begin
                    cnt_next = '0;
                    if (len_reg >= LEN_W'(2))
                    begin
                        mode_next  = MODE_PERM;
                        k_next     = '0;
                        state_next = ST_XA;
                    end
                    else
                    begin
                        state_next = ST_EM_RD;
                    end
                end
            end

            ST_XA:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = x_addr;
                state_next  = ST_XB;
            end

            ST_XB:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = y_addr;
                a_next      = mem_rd_data;
                state_next  = ST_XC;
            end

            ST_XC:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = x_addr;
                mem_wr_data = swap_rsp.first;
                b_next      = swap_rsp.second;
                state_next  = ST_XD;
            end

            ST_XD:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = y_addr;
                mem_wr_data = b_reg;
                if (mode_reg == MODE_SORT)
                begin
                    if (({1'b0, k_reg} + LEN_W'(2)) < (len_reg - {1'b0, pass_reg}))
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_XA;
                    end
                    else
                    begin
                        k_next    = '0;
                        pass_next = pass_reg + IDX_W'(1);
                        if (({1'b0, pass_reg} + LEN_W'(2)) < len_reg)
                        begin
                            state_next = ST_XA;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    if (({1'b0, k_reg} + LEN_W'(2)) < len_reg)
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_XA;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = ST_EM_RD;
                    end
                end
            end

            ST_EM_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = {1'b1, cnt_reg[IDX_W-1:0]};
                state_next  = ST_EM_LD;
            end

            ST_EM_LD:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_char_next = mem_rd_data;
                    out_last_next = emit_last;
                    out_exh_next  = 1'b0;
                    if (emit_last)
                    begin
                        k_next     = IDX_W'(len_reg - LEN_W'(2));
                        state_next = ST_ADV;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + LEN_W'(1);
                        state_next = ST_EM_RD;
                    end
                end
            end

            ST_ADV:
            begin
                // walk levels downward until one still has a partner to try
                swap_req.force_swap = 1'b0;
                swap_req.a          = CHAR_W'(len_reg);
                swap_req.b          = CHAR_W'(choice) + CHAR_W'(1);
                if (len_reg < LEN_W'(2))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (swap_rsp.gt)
                begin
                    stack_cmd.bump = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (k_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next = k_reg - IDX_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_SORT;
            len_reg       <= '0;
            closed_reg    <= 1'b0;
            done_reg      <= 1'b1;
            k_reg         <= '0;
            pass_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            len_reg    <= len_next;
            closed_reg <= closed_next;
            done_reg   <= done_next;
            k_reg      <= k_next;
            pass_reg   <= pass_next;
            cnt_reg    <= cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        if (out_load)
        begin
            out_char_reg <= out_char_next;
            out_last_reg <= out_last_next;
            out_exh_reg  <= out_exh_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign char_out     = out_char_reg;
    assign last_of_perm = out_last_reg;
    assign exhausted    = out_exh_reg;

    // the exhausted result is always a lone zero marked last
    a_exh_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_exh_reg) |-> (out_last_reg && (out_char_reg == '0)))
        else $error("exhausted result malformed");

    // stored length never passes the cap
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_LEN))
        else $error("word length above cap");

    // closing a word always leaves a permutation pending
    a_close_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && (action == ACT_LOAD) && last_char) |=> !done_reg)
        else $error("closed word left nothing pending");

    // pair steps only run on words of two or more characters
    a_pair_len: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_XA) || (state_reg == ST_XB) || (state_reg == ST_XC)
            || (state_reg == ST_XD)) |-> (len_reg >= LEN_W'(2)))
        else $error("pair step on short word");

endmodule

@@ tb/sorted_permutation_generator_top_tb.sv @@
// self-checking testbench for the sorted permutation generator top level
module sorted_permutation_generator_top_tb;
    import spg_pkg::*;

    localparam int MAX_CHARS   = DEF_MAX_LEN;
    localparam int TAIL_CYCLES = 300;       // longest sort plus one full permutation walk
    localparam int HOLD_CYCLES = 400;       // long receiver hold to back the block up

    typedef struct packed {
        logic              action;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } request_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last_of_perm;
        logic              exhausted;
    } perm_char_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_ready;
    logic              action       = ACT_LOAD;
    logic [CHAR_W-1:0] char_value   = '0;
    logic              last_char    = 1'b0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic [CHAR_W-1:0] char_out;
    logic              last_of_perm;
    logic              exhausted;

    sorted_permutation_generator_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .char_value   (char_value),
        .last_char    (last_char),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .char_out     (char_out),
        .last_of_perm (last_of_perm),
        .exhausted    (exhausted)
    );

    always #4 clk = ~clk;

    // requests still to be sent and characters still expected back
    request_t   pending_requests[$];
    perm_char_t expected_chars[$];

    int  mismatches   = 0;
    int  results_seen = 0;
    logic long_hold   = 1'b0;

    // predictor state: the word, the swap partner per level and the enumeration flags
    logic [CHAR_W-1:0] word_chars[STORE_DEPTH];
    logic [IDX_W-1:0]  swap_pick[STORE_DEPTH];
    int                word_len    = 0;
    bit                enum_done   = 1'b1;
    bit                word_sealed = 1'b0;

    // update the predictor with one accepted request, queue any characters it yields
    task automatic predict_request(input request_t r);
        logic [CHAR_W-1:0] perm[STORE_DEPTH];
        logic [CHAR_W-1:0] t;
        perm_char_t        pc;
        int                l, k, j;
        bit                found;
        if (r.action == ACT_LOAD)
        begin
            // a load after a closed word starts a fresh one
            if (word_sealed)
            begin
                word_len    = 0;
                word_sealed = 1'b0;
            end
            // characters past the maximum length are dropped
            if (word_len < MAX_CHARS)
            begin
                word_chars[word_len] = r.ch;
                word_len++;
            end
            if (r.last)
            begin
                // ascending bubble sort, then restart the odometer
                for (l = 0; l + 1 < word_len; l++)
                    for (k = 0; k + 1 < word_len - l; k++)
                        if (word_chars[k] > word_chars[k + 1])
                        begin
                            t                 = word_chars[k];
                            word_chars[k]     = word_chars[k + 1];
                            word_chars[k + 1] = t;
                        end
                for (l = 0; l < STORE_DEPTH; l++)
                    swap_pick[l] = IDX_W'(l);
                enum_done   = (word_len == 0);
                word_sealed = 1'b1;
            end
            else
                enum_done = 1'b1;
        end
        else if (enum_done || word_len == 0)
        begin
            pc.ch           = '0;
            pc.last_of_perm = 1'b1;
            pc.exhausted    = 1'b1;
            expected_chars.push_back(pc);
        end
        else
        begin
            // level l swaps position l with its chosen partner
            perm = word_chars;
            for (l = 0; l + 1 < word_len; l++)
            begin
                j = int'(swap_pick[l]);
                if (j < word_len)
                begin
                    t       = perm[l];
                    perm[l] = perm[j];
                    perm[j] = t;
                end
            end
            for (k = 0; k < word_len; k++)
            begin
                pc.ch           = perm[k];
                pc.last_of_perm = (k + 1 == word_len);
                pc.exhausted    = 1'b0;
                expected_chars.push_back(pc);
            end
            // step the odometer: bump the deepest level that still has a partner left
            found = 1'b0;
            if (word_len >= 2)
            begin
                l = word_len - 1;
                while (l > 0 && !found)
                begin
                    l--;
                    if (int'(swap_pick[l]) + 1 < word_len)
                    begin
                        swap_pick[l] = swap_pick[l] + IDX_W'(1);
                        for (k = l + 1; k < STORE_DEPTH; k++)
                            swap_pick[k] = IDX_W'(k);
                        found = 1'b1;
                    end
                end
            end
            if (!found)
                enum_done = 1'b1;
        end
    endtask

    task automatic add_load(input logic [CHAR_W-1:0] ch, input logic last);
        request_t r;
        r.action = ACT_LOAD;
        r.ch     = ch;
        r.last   = last;
        pending_requests.push_back(r);
    endtask

    // next request; the character and last fields are don't-care and randomized
    task automatic add_next();
        request_t r;
        r.action = ACT_NEXT;
        r.ch     = CHAR_W'($urandom_range(0, 255));
        r.last   = 1'($urandom_range(0, 1));
        pending_requests.push_back(r);
    endtask

    // whole word with random characters, narrow alphabet makes repeats likely
    task automatic add_word(input int len, input bit narrow);
        int i;
        for (i = 0; i < len; i++)
            add_load(narrow ? CHAR_W'($urandom_range(65, 67)) : CHAR_W'($urandom_range(0, 255)),
                     i == len - 1);
    endtask

    task automatic add_nexts(input int count);
        int i;
        for (i = 0; i < count; i++)
            add_next();
    endtask

    task automatic flag_mismatch(input string what, input perm_char_t want,
                                 input perm_char_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"mismatch (%s): expected char %02h last %0b exh %0b,",
                      " got char %02h last %0b exh %0b"},
                     what, want.ch, want.last_of_perm, want.exhausted,
                     got.ch, got.last_of_perm, got.exhausted);
    endtask

    // driver: bursts of requests with random gaps between them
    always @(posedge clk)
    begin : driver
        request_t r;
        bit       drive_now;
        int       burst_left;
        int       gap_left;
        if (rst_n)
        begin
            drive_now = 1'b0;
            if (item_valid && item_ready)
            begin
                r.action = action;
                r.ch     = char_value;
                r.last   = last_char;
                predict_request(r);
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    // some bursts run straight into the next one
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    burst_left = $urandom_range(1, 24);
                end
            end
            if (!item_valid || item_ready)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_requests.size() > 0)
                    drive_now = 1'b1;
                if (drive_now)
                begin
                    r          = pending_requests.pop_front();
                    item_valid <= 1'b1;
                    action     <= r.action;
                    char_value <= r.ch;
                    last_char  <= r.last;
                end
                else
                    item_valid <= 1'b0;
            end
        end
        else
        begin
            burst_left = $urandom_range(1, 24);
            gap_left   = 0;
        end
    end

    // receiver: stall pattern changes from phase to phase
    always @(posedge clk)
    begin : receiver
        int   phase_left;
        int   mode;
        logic rdy;
        if (phase_left == 0)
        begin
            mode       = $urandom_range(0, 3);
            phase_left = $urandom_range(20, 120);
        end
        else
            phase_left--;
        case (mode)
            0:       rdy = 1'b1;
            1:       rdy = ($urandom_range(0, 3) != 0);
            2:       rdy = 1'($urandom_range(0, 1));
            default: rdy = ~result_ready;
        endcase
        if (long_hold)
            rdy = 1'b0;
        result_ready <= rdy;
    end

    // monitor: every accepted result against the oldest expected character
    always @(posedge clk)
    begin : monitor
        perm_char_t got;
        perm_char_t want;
        if (rst_n && result_valid && result_ready)
        begin
            got.ch           = char_out;
            got.last_of_perm = last_of_perm;
            got.exhausted    = exhausted;
            results_seen++;
            if (expected_chars.size() == 0)
            begin
                want = '0;
                flag_mismatch("unexpected result", want, got);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (got.ch !== want.ch)
                    flag_mismatch("char_out", want, got);
                else if (got.last_of_perm !== want.last_of_perm)
                    flag_mismatch("last_of_perm", want, got);
                else if (got.exhausted !== want.exhausted)
                    flag_mismatch("exhausted", want, got);
            end
        end
    end

    // one long receiver hold while the sender keeps going, fills the block up
    initial
    begin
        while (results_seen < 40)
            @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("** sorted_permutation_generator_top: FAILED **");
        $finish;
    end

    initial
    begin
        int directed_count;
        int kind;
        int len;
        int full_count;
        int i;

        // directed: next on an empty store gives the exhausted result
        add_next();
        // single character: one permutation, then exhausted
        add_load(8'h00, 1'b1);
        add_nexts(2);
        // three extreme characters, sorted, two permutations
        add_load(8'hFF, 1'b0);
        add_load(8'h01, 1'b0);
        add_load(8'h80, 1'b1);
        add_nexts(2);
        // open load on a closed word: new word, enumeration stopped
        add_load(8'h41, 1'b0);
        add_next();
        // closing it: two permutations then the exhausted result
        add_load(8'h42, 1'b1);
        add_nexts(3);
        // word too long: ninth character dropped, its last flag still closes the word
        for (i = 0; i < MAX_CHARS; i++)
            add_load(CHAR_W'(8'hF0 - 8'(i * 17)), 1'b0);
        add_load(8'h7F, 1'b1);
        add_nexts(2);
        directed_count = pending_requests.size();

        // random: mostly whole words followed by runs of next requests
        while (pending_requests.size() < directed_count + 200)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(1, 3);
                    6, 7:             len = 4;
                    8:                len = $urandom_range(5, MAX_CHARS);
                    default:          len = MAX_CHARS + 1;
                endcase
                add_word(len, $urandom_range(0, 1));
                if (len <= 4)
                begin
                    full_count = 1;
                    for (i = 2; i <= len; i++)
                        full_count *= i;
                    // usually the full walk into exhaustion, sometimes cut short
                    if ($urandom_range(0, 3) == 0)
                        add_nexts($urandom_range(1, full_count));
                    else
                        add_nexts(full_count + $urandom_range(1, 2));
                end
                else
                    add_nexts($urandom_range(1, 6));
            end
            else if (kind == 7)
            begin
                // word never closed: next requests see nothing pending
                for (i = $urandom_range(1, 3); i > 0; i--)
                    add_load(CHAR_W'($urandom_range(0, 255)), 1'b0);
                add_nexts($urandom_range(1, 2));
            end
            else if (kind == 8)
                add_next();
            else
            begin
                // enumeration broken off by an open load
                add_word($urandom_range(2, 4), 1'b0);
                add_nexts($urandom_range(1, 3));
                add_load(CHAR_W'($urandom_range(0, 255)), 1'b0);
                add_next();
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_requests.size() > 0 || item_valid)
            @(posedge clk);
        while (expected_chars.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_chars.size() == 0)
            $display("** sorted_permutation_generator_top: PASSED **");
        else
            $display("** sorted_permutation_generator_top: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
rtl/spg_pkg.sv
rtl/spg_mem.sv
rtl/spg_swap_unit.sv
rtl/spg_stack.sv
rtl/sorted_permutation_generator_top.sv
tb/sorted_permutation_generator_top_tb.sv
